/* src/tdpu_pkg.sv */
// Shared types, decode constants and datapath functions for the Thumb data-processing unit.
`default_nettype none

package tdpu_pkg;

	localparam int unsigned NumRegs  = 8;
	localparam int unsigned RegAw    = $clog2(NumRegs);
	localparam int unsigned DataW    = 32;
	localparam int unsigned InsW     = 16;
	localparam int unsigned TdataOutW = 40;
	localparam int unsigned TuserOutW = 2;

	// Opcode prefixes of the supported formats.
	localparam logic [4:0] FmtAddSub  = 5'b00011;
	localparam logic [2:0] FmtShift   = 3'b000;
	localparam logic [2:0] FmtImm8    = 3'b001;
	localparam logic [5:0] FmtAluReg  = 6'b010000;

	typedef enum logic [1:0] {
		SH_LSL = 2'd0,
		SH_LSR = 2'd1,
		SH_ASR = 2'd2,
		SH_ROR = 2'd3
	} shift_kind_t;

	typedef enum logic [1:0] {
		IMM_MOV = 2'd0,
		IMM_CMP = 2'd1,
		IMM_ADD = 2'd2,
		IMM_SUB = 2'd3
	} imm_op_t;

	typedef enum logic [3:0] {
		ALU_AND = 4'h0,
		ALU_EOR = 4'h1,
		ALU_LSL = 4'h2,
		ALU_LSR = 4'h3,
		ALU_ASR = 4'h4,
		ALU_ADC = 4'h5,
		ALU_SBC = 4'h6,
		ALU_ROR = 4'h7,
		ALU_TST = 4'h8,
		ALU_NEG = 4'h9,
		ALU_CMP = 4'hA,
		ALU_CMN = 4'hB,
		ALU_ORR = 4'hC,
		ALU_MUL = 4'hD,
		ALU_BIC = 4'hE,
		ALU_MVN = 4'hF
	} alu_op_t;

	typedef struct packed {
		logic [3:0]       nzcv;
		logic [DataW-1:0] value;
	} sum_t;

	typedef struct packed {
		logic             carry;
		logic [DataW-1:0] value;
	} shift_t;

	typedef struct packed {
		logic [RegAw-1:0] dest_index;
		logic [DataW-1:0] write_value;
		logic             wrote;
		logic [3:0]       flags_nzcv;
		logic             unsupported;
	} exec_result_t;

	typedef logic [NumRegs-1:0] reg_valid_t;

	function automatic logic [1:0] nz_of(input logic [DataW-1:0] r);
		nz_of = {r[DataW-1], (r == '0)};
	endfunction

	function automatic sum_t add_op(input logic [DataW-1:0] a, input logic [DataW-1:0] b,
		input logic cin);
		logic [DataW:0]   s;
		logic [DataW-1:0] r;
		logic             v;
		s = {1'b0, a} + {1'b0, b} + {{DataW{1'b0}}, cin};
		r = s[DataW-1:0];
		v = ~(a[DataW-1] ^ b[DataW-1]) & (a[DataW-1] ^ r[DataW-1]);
		add_op.value = r;
		add_op.nzcv  = {nz_of(r), s[DataW], v};
	endfunction

	// Barrel shifter with ARM carry-out rules; an amount of zero passes the value and carry.
	function automatic shift_t shift_op(input shift_kind_t kind, input logic [DataW-1:0] v,
		input logic [7:0] amt, input logic cin);
		logic [DataW:0]     t;
		logic [2*DataW-1:0] w;
		logic               below;
		logic               exact;
		shift_op.carry = cin;
		shift_op.value = v;
		below = (amt < 8'd32);
		exact = (amt == 8'd32);
		t = '0;
		w = '0;
		if (amt != 8'd0) begin
			unique case (kind)
				SH_LSL: begin
					t = {1'b0, v} << amt[4:0];
					if (below) begin
						shift_op.carry = t[DataW];
						shift_op.value = t[DataW-1:0];
					end else begin
						shift_op.carry = exact & v[0];
						shift_op.value = '0;
					end
				end
				SH_LSR: begin
					t = {v, 1'b0} >> amt[4:0];
					if (below) begin
						shift_op.carry = t[0];
						shift_op.value = t[DataW:1];
					end else begin
						shift_op.carry = exact & v[DataW-1];
						shift_op.value = '0;
					end
				end
				SH_ASR: begin
					t = $unsigned($signed({v, 1'b0}) >>> amt[4:0]);
					if (below) begin
						shift_op.carry = t[0];
						shift_op.value = t[DataW:1];
					end else begin
						shift_op.carry = v[DataW-1];
						shift_op.value = {DataW{v[DataW-1]}};
					end
				end
				SH_ROR: begin
					w = {v, v} >> amt[4:0];
					shift_op.value = w[DataW-1:0];
					shift_op.carry = w[DataW-1];
				end
				default: begin
					shift_op.value = v;
				end
			endcase
		end
	endfunction

endpackage

`default_nettype wire

/* src/tdpu_ram.sv */
// Generic RAM with one write port and two registered read ports.
`default_nettype none

module tdpu_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_a,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

`default_nettype wire

/* src/tdpu_exec.sv */
// Combinational execute logic for Thumb formats 1 to 4: decode, adder, shifter and multiplier.
`default_nettype none

module tdpu_exec (
	input  wire logic [tdpu_pkg::InsW-1:0]  instruction,
	input  wire logic [tdpu_pkg::DataW-1:0] op_a,
	input  wire logic [tdpu_pkg::DataW-1:0] op_b,
	input  wire logic [3:0]                 flags,
	output tdpu_pkg::exec_result_t          result
);
	import tdpu_pkg::*;

	logic [DataW-1:0] imm8;
	logic [DataW-1:0] imm3;
	logic [DataW-1:0] add_b;
	logic [DataW-1:0] prod;
	logic [7:0]       sh_amt;
	logic [4:0]       amt5;
	logic             cin;
	sum_t             sum;
	shift_t           sh;
	logic [RegAw-1:0] rd;
	logic [DataW-1:0] res;
	logic             wr;
	logic             unsup;
	logic [3:0]       nf;

	assign cin  = flags[1];
	assign imm8 = {{(DataW-8){1'b0}}, instruction[7:0]};
	assign imm3 = {{(DataW-3){1'b0}}, instruction[8:6]};
	assign amt5 = instruction[10:6];
	assign prod = op_a * op_b;

	always_comb begin
		rd     = '0;
		res    = '0;
		wr     = 1'b0;
		unsup  = 1'b0;
		nf     = flags;
		sum    = '0;
		sh     = '0;
		add_b  = '0;
		sh_amt = '0;
		if (instruction[15:11] == FmtAddSub) begin
			rd    = instruction[2:0];
			add_b = instruction[10] ? imm3 : op_b;
			if (instruction[9]) begin
				sum = add_op(op_a, ~add_b, 1'b1);
			end else begin
				sum = add_op(op_a, add_b, 1'b0);
			end
			res = sum.value;
			nf  = sum.nzcv;
			wr  = 1'b1;
		end else if (instruction[15:13] == FmtShift) begin
			rd = instruction[2:0];
			// An immediate LSR or ASR of zero encodes a shift by 32.
			if (instruction[12:11] != SH_LSL && amt5 == 5'd0) begin
				sh_amt = 8'd32;
			end else begin
				sh_amt = {3'b000, amt5};
			end
			sh  = shift_op(shift_kind_t'(instruction[12:11]), op_a, sh_amt, cin);
			res = sh.value;
			nf  = {nz_of(sh.value), sh.carry, flags[0]};
			wr  = 1'b1;
		end else if (instruction[15:13] == FmtImm8) begin
			rd = instruction[10:8];
			unique case (imm_op_t'(instruction[12:11]))
				IMM_MOV: begin
					res = imm8;
					nf  = {nz_of(imm8), flags[1:0]};
					wr  = 1'b1;
				end
				IMM_CMP: begin
					sum = add_op(op_a, ~imm8, 1'b1);
					nf  = sum.nzcv;
				end
				IMM_ADD: begin
					sum = add_op(op_a, imm8, 1'b0);
					res = sum.value;
					nf  = sum.nzcv;
					wr  = 1'b1;
				end
				IMM_SUB: begin
					sum = add_op(op_a, ~imm8, 1'b1);
					res = sum.value;
					nf  = sum.nzcv;
					wr  = 1'b1;
				end
				default: begin
					unsup = 1'b1;
				end
			endcase
		end else if (instruction[15:10] == FmtAluReg) begin
			rd = instruction[2:0];
			wr = 1'b1;
			unique case (alu_op_t'(instruction[9:6]))
				ALU_AND: begin
					res = op_a & op_b;
					nf  = {nz_of(res), flags[1:0]};
				end
				ALU_EOR: begin
					res = op_a ^ op_b;
					nf  = {nz_of(res), flags[1:0]};
				end
				ALU_LSL, ALU_LSR, ALU_ASR, ALU_ROR: begin
					unique case (alu_op_t'(instruction[9:6]))
						ALU_LSL: sh = shift_op(SH_LSL, op_a, op_b[7:0], cin);
						ALU_LSR: sh = shift_op(SH_LSR, op_a, op_b[7:0], cin);
						ALU_ASR: sh = shift_op(SH_ASR, op_a, op_b[7:0], cin);
						default: sh = shift_op(SH_ROR, op_a, op_b[7:0], cin);
					endcase
					res = sh.value;
					nf  = {nz_of(sh.value), sh.carry, flags[0]};
				end
				ALU_ADC: begin
					sum = add_op(op_a, op_b, cin);
					res = sum.value;
					nf  = sum.nzcv;
				end
				ALU_SBC: begin
					sum = add_op(op_a, ~op_b, cin);
					res = sum.value;
					nf  = sum.nzcv;
				end
				ALU_TST: begin
					nf = {nz_of(op_a & op_b), flags[1:0]};
					wr = 1'b0;
				end
				ALU_NEG: begin
					sum = add_op('0, ~op_b, 1'b1);
					res = sum.value;
					nf  = sum.nzcv;
				end
				ALU_CMP: begin
					sum = add_op(op_a, ~op_b, 1'b1);
					nf  = sum.nzcv;
					wr  = 1'b0;
				end
				ALU_CMN: begin
					sum = add_op(op_a, op_b, 1'b0);
					nf  = sum.nzcv;
					wr  = 1'b0;
				end
				ALU_ORR: begin
					res = op_a | op_b;
					nf  = {nz_of(res), flags[1:0]};
				end
				ALU_MUL: begin
					// MUL clears C and keeps V.
					res = prod;
					nf  = {nz_of(prod), 1'b0, flags[0]};
				end
				ALU_BIC: begin
					res = op_a & ~op_b;
					nf  = {nz_of(res), flags[1:0]};
				end
				ALU_MVN: begin
					res = ~op_b;
					nf  = {nz_of(res), flags[1:0]};
				end
				default: begin
					wr = 1'b0;
				end
			endcase
		end else begin
			unsup = 1'b1;
		end
	end

	assign result.dest_index  = rd;
	assign result.write_value = wr ? res : '0;
	assign result.wrote       = wr;
	assign result.flags_nzcv  = nf;
	assign result.unsupported = unsup;

endmodule

`default_nettype wire

/* src/thumb_data_processing_unit.sv */
// Top level of the Thumb data-processing unit: operand read, execute stage and output register.
//
// The block executes one 16-bit Thumb instruction (formats 1 to 4) per input item on
// s_tdata and returns one result item per instruction on the m_t* channel. It keeps
// eight 32-bit low registers and the NZCV flags between items.
// Operands are read from the register file in the cycle an item is accepted; the
// item then sits in the execute stage, where it updates the registers and flags as it
// moves into the output register, which drives m_tvalid. Throughput is one item per
// cycle while m_tready is high: the register file has two registered read ports,
// and a write that lands at the same edge as a read is bypassed to the next item.
// When m_tready is low the output register holds its item, the execute stage holds
// one more, and s_tready drops until space opens up; no item is lost or repeated.
// Reset clears the flags and marks every register as never written, so all
// registers read as zero at once; no clearing pass is needed.
`default_nettype none

module thumb_data_processing_unit (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// s_tdata: [15:0] instruction
	input  wire logic [tdpu_pkg::InsW-1:0]        s_tdata,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// m_tdata: [2:0] dest_index, [34:3] write_value, [38:35] flags_nzcv, [39] zero
	output logic      [tdpu_pkg::TdataOutW-1:0]   m_tdata,
	// m_tuser: [0] wrote, [1] unsupported
	output logic      [tdpu_pkg::TuserOutW-1:0]   m_tuser
);
	import tdpu_pkg::*;

	logic             accept;
	logic             advance;
	logic             wr_en;
	logic [RegAw-1:0] waddr;
	logic [RegAw-1:0] raddr_a;
	logic [RegAw-1:0] raddr_b;
	logic [DataW-1:0] ram_a;
	logic [DataW-1:0] ram_b;
	logic [DataW-1:0] op_a;
	logic [DataW-1:0] op_b;
	exec_result_t     res;

	logic             valid_s1;
	logic [InsW-1:0]  ins_s1;
	logic             vld_a_s1;
	logic             vld_b_s1;
	logic             byp_a_s1;
	logic             byp_b_s1;
	logic [DataW-1:0] byp_data_s1;

	reg_valid_t       reg_valid_q;
	logic [3:0]       flags_q;
	logic             out_valid_q;
	exec_result_t     out_q;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign accept   = s_tvalid && s_tready;
	assign wr_en    = advance && res.wrote;
	assign waddr    = res.dest_index;

	// Port A serves the first operand of each format, port B the second.
	always_comb begin
		if (s_tdata[15:13] == FmtImm8) begin
			raddr_a = s_tdata[10:8];
		end else if (s_tdata[15:10] == FmtAluReg) begin
			raddr_a = s_tdata[2:0];
		end else begin
			raddr_a = s_tdata[5:3];
		end
		if (s_tdata[15:10] == FmtAluReg) begin
			raddr_b = s_tdata[5:3];
		end else begin
			raddr_b = s_tdata[8:6];
		end
	end

	tdpu_ram #(
		.WIDTH (DataW),
		.DEPTH (NumRegs)
	) u_regfile (
		.clk     (clk),
		.we      (wr_en),
		.waddr   (waddr),
		.wdata   (res.write_value),
		.re      (accept),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (ram_a),
		.rdata_b (ram_b)
	);

	always_comb begin
		if (byp_a_s1) begin
			op_a = byp_data_s1;
		end else begin
			op_a = vld_a_s1 ? ram_a : '0;
		end
		if (byp_b_s1) begin
			op_b = byp_data_s1;
		end else begin
			op_b = vld_b_s1 ? ram_b : '0;
		end
	end

	tdpu_exec u_exec (
		.instruction (ins_s1),
		.op_a        (op_a),
		.op_b        (op_b),
		.flags       (flags_q),
		.result      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			reg_valid_q <= '0;
			flags_q     <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
				flags_q     <= res.flags_nzcv;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (wr_en) begin
				reg_valid_q[waddr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ins_s1      <= s_tdata;
			vld_a_s1    <= reg_valid_q[raddr_a];
			vld_b_s1    <= reg_valid_q[raddr_b];
			byp_a_s1    <= wr_en && (waddr == raddr_a);
			byp_b_s1    <= wr_en && (waddr == raddr_b);
			byp_data_s1 <= res.write_value;
		end
		if (advance) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_q.flags_nzcv, out_q.write_value, out_q.dest_index};
	assign m_tuser  = {out_q.unsupported, out_q.wrote};

endmodule

`default_nettype wire

/* tb/tdpu_exec_checker.sv */
// Checker for the Thumb data-processing unit: predicts each result item and compares it.
module tdpu_exec_checker (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	input  wire logic                           s_tready,
	input  wire logic [tdpu_pkg::InsW-1:0]      s_tdata,
	input  wire logic                           m_tvalid,
	input  wire logic                           m_tready,
	input  wire logic [tdpu_pkg::TdataOutW-1:0] m_tdata,
	input  wire logic [tdpu_pkg::TuserOutW-1:0] m_tuser,
	output int                                  mismatches,
	output int                                  pending,
	output int                                  checked,
	output int                                  unsupported_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	import tdpu_pkg::*;

	typedef struct {
		logic [InsW-1:0] ins;
		exec_result_t    res;
	} exec_entry_t;

	// Architectural copy of the register file and flags.
	logic [DataW-1:0] regs [NumRegs];
	logic [3:0]       flags;

	exec_entry_t      expected_results [$];
	exec_entry_t      oldest;
	exec_result_t     got;
	logic             got_pad;

	function automatic logic [1:0] sign_zero(input logic [DataW-1:0] r);
		return {r[DataW-1], r == '0};
	endfunction

	// Returns {N, Z, C, V, sum} of a + b + cin.
	function automatic logic [DataW+3:0] add_with_flags(input logic [DataW-1:0] a,
		input logic [DataW-1:0] b, input logic cin);
		logic [DataW:0]   s;
		logic [DataW-1:0] r;
		logic [DataW-1:0] ovf;
		s = {1'b0, a} + {1'b0, b} + {{DataW{1'b0}}, cin};
		r = s[DataW-1:0];
		ovf = ~(a ^ b) & (a ^ r);
		return {sign_zero(r), s[DataW], ovf[DataW-1], r};
	endfunction

	// Returns {carry, value}; an amount of zero passes the value and the incoming carry.
	function automatic logic [DataW:0] barrel(input shift_kind_t kind,
		input logic [DataW-1:0] v, input logic [7:0] amt, input logic cin);
		logic sgn;
		int   n;
		sgn = v[DataW-1];
		n = int'(amt[4:0]);
		if (amt == 8'd0)
			return {cin, v};
		case (kind)
			SH_LSL: begin
				if (amt < 8'd32)
					return {v[32 - int'(amt)], v << amt};
				return {(amt == 8'd32) & v[0], {DataW{1'b0}}};
			end
			SH_LSR: begin
				if (amt < 8'd32)
					return {v[int'(amt) - 1], v >> amt};
				return {(amt == 8'd32) & sgn, {DataW{1'b0}}};
			end
			SH_ASR: begin
				if (amt < 8'd32)
					return {v[int'(amt) - 1], DataW'($signed(v) >>> amt)};
				return {sgn, {DataW{sgn}}};
			end
			default: begin
				if (n == 0)
					return {sgn, v};
				return {v[n-1], (v >> n) | (v << (32 - n))};
			end
		endcase
	endfunction

	// Executes one instruction against the local state and returns the result item.
	function automatic exec_result_t execute_thumb(input logic [InsW-1:0] ins);
		logic [3:0]       nf;
		logic [DataW-1:0] a;
		logic [DataW-1:0] b;
		logic [DataW-1:0] res;
		logic [DataW-1:0] imm;
		logic [DataW:0]   sh;
		logic [7:0]       amt;
		logic [2:0]       rd;
		logic             wr;
		logic             unsup;
		logic             shifted;
		exec_result_t     r;
		nf = flags;
		res = '0;
		rd = '0;
		wr = 1'b0;
		unsup = 1'b0;
		shifted = 1'b0;
		sh = '0;
		if (ins[15:11] == FmtAddSub) begin
			a = regs[ins[5:3]];
			b = ins[10] ? {29'd0, ins[8:6]} : regs[ins[8:6]];
			if (ins[9])
				{nf, res} = add_with_flags(a, ~b, 1'b1);
			else
				{nf, res} = add_with_flags(a, b, 1'b0);
			rd = ins[2:0];
			wr = 1'b1;
		end else if (ins[15:13] == FmtShift) begin
			// LSR and ASR by an immediate of zero mean a shift by 32.
			amt = {3'd0, ins[10:6]};
			if (ins[12:11] != SH_LSL && amt == 8'd0)
				amt = 8'd32;
			sh = barrel(shift_kind_t'(ins[12:11]), regs[ins[5:3]], amt, flags[1]);
			shifted = 1'b1;
			rd = ins[2:0];
			wr = 1'b1;
		end else if (ins[15:13] == FmtImm8) begin
			rd = ins[10:8];
			a = regs[rd];
			imm = {24'd0, ins[7:0]};
			case (imm_op_t'(ins[12:11]))
				IMM_MOV: begin
					res = imm;
					nf = {sign_zero(imm), flags[1:0]};
					wr = 1'b1;
				end
				IMM_CMP: begin
					{nf, res} = add_with_flags(a, ~imm, 1'b1);
				end
				IMM_ADD: begin
					{nf, res} = add_with_flags(a, imm, 1'b0);
					wr = 1'b1;
				end
				default: begin
					{nf, res} = add_with_flags(a, ~imm, 1'b1);
					wr = 1'b1;
				end
			endcase
		end else if (ins[15:10] == FmtAluReg) begin
			rd = ins[2:0];
			a = regs[rd];
			b = regs[ins[5:3]];
			wr = 1'b1;
			case (alu_op_t'(ins[9:6]))
				ALU_AND: begin res = a & b; nf = {sign_zero(res), flags[1:0]}; end
				ALU_EOR: begin res = a ^ b; nf = {sign_zero(res), flags[1:0]}; end
				ALU_LSL: begin sh = barrel(SH_LSL, a, b[7:0], flags[1]); shifted = 1'b1; end
				ALU_LSR: begin sh = barrel(SH_LSR, a, b[7:0], flags[1]); shifted = 1'b1; end
				ALU_ASR: begin sh = barrel(SH_ASR, a, b[7:0], flags[1]); shifted = 1'b1; end
				ALU_ADC: {nf, res} = add_with_flags(a, b, flags[1]);
				ALU_SBC: {nf, res} = add_with_flags(a, ~b, flags[1]);
				ALU_ROR: begin sh = barrel(SH_ROR, a, b[7:0], flags[1]); shifted = 1'b1; end
				ALU_TST: begin nf = {sign_zero(a & b), flags[1:0]}; wr = 1'b0; end
				ALU_NEG: {nf, res} = add_with_flags('0, ~b, 1'b1);
				ALU_CMP: begin {nf, res} = add_with_flags(a, ~b, 1'b1); wr = 1'b0; end
				ALU_CMN: begin {nf, res} = add_with_flags(a, b, 1'b0); wr = 1'b0; end
				ALU_ORR: begin res = a | b; nf = {sign_zero(res), flags[1:0]}; end
				ALU_MUL: begin res = a * b; nf = {sign_zero(res), 1'b0, flags[0]}; end
				ALU_BIC: begin res = a & ~b; nf = {sign_zero(res), flags[1:0]}; end
				ALU_MVN: begin res = ~b; nf = {sign_zero(res), flags[1:0]}; end
			endcase
		end else begin
			unsup = 1'b1;
		end
		if (shifted) begin
			res = sh[DataW-1:0];
			nf = {sign_zero(res), sh[DataW], flags[0]};
		end
		if (!unsup) begin
			flags = nf;
			if (wr)
				regs[rd] = res;
		end
		r.dest_index = rd;
		r.write_value = wr ? res : '0;
		r.wrote = wr;
		r.flags_nzcv = flags;
		r.unsupported = unsup;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (regs[i])
				regs[i] = '0;
			flags = '0;
			expected_results.delete();
			mismatches = 0;
			pending = 0;
			checked = 0;
			unsupported_seen = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.dest_index = m_tdata[2:0];
				got.write_value = m_tdata[34:3];
				got.flags_nzcv = m_tdata[38:35];
				got.wrote = m_tuser[0];
				got.unsupported = m_tuser[1];
				got_pad = m_tdata[39];
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result item with none expected: rd=%0d val=%08h",
							$realtime, got.dest_index, got.write_value);
				end else begin
					oldest = expected_results.pop_front();
					checked++;
					if (oldest.res.unsupported)
						unsupported_seen++;
					if (got.dest_index !== oldest.res.dest_index ||
						got.write_value !== oldest.res.write_value ||
						got.wrote !== oldest.res.wrote ||
						got.flags_nzcv !== oldest.res.flags_nzcv ||
						got.unsupported !== oldest.res.unsupported ||
						got_pad !== 1'b0) begin
						mismatches++;
						if (mismatches <= 10) begin
							$write("%0t: ins %04h expected rd=%0d val=%08h wr=%0b nzcv=%04b ",
								$realtime, oldest.ins, oldest.res.dest_index,
								oldest.res.write_value, oldest.res.wrote,
								oldest.res.flags_nzcv);
							$display("unsup=%0b, got rd=%0d val=%08h wr=%0b nzcv=%04b %s%0b pad=%0b",
								oldest.res.unsupported, got.dest_index, got.write_value,
								got.wrote, got.flags_nzcv, "unsup=", got.unsupported,
								got_pad);
						end
					end
				end
			end
			if (s_tvalid && s_tready)
				expected_results.push_back('{ins: s_tdata, res: execute_thumb(s_tdata)});
			pending = expected_results.size();
		end
	end

endmodule

/* tb/tb_thumb_data_processing_unit.sv */
// Top-level testbench for the Thumb data-processing unit: stimulus, flow control and verdict.
module tb_thumb_data_processing_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import tdpu_pkg::*;

	localparam int ItemCount  = 750;
	localparam int QuietFrom  = 600;
	localparam int StallLimit = 2000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic [InsW-1:0]      s_tdata = '0;
	logic                 m_tready = 1'b0;
	wire logic            s_tready;
	wire logic            m_tvalid;
	wire logic [TdataOutW-1:0] m_tdata;
	wire logic [TuserOutW-1:0] m_tuser;

	int   mismatches;
	int   pending;
	int   checked;
	int   unsupported_seen;
	int   sent = 0;
	int   quiet_cycles = 0;
	int   stall_left = 0;
	logic src_gaps = 1'b1;
	logic sink_stalls = 1'b1;

	logic [7:0] imm_corners [6] = '{8'd0, 8'd1, 8'd31, 8'd32, 8'd33, 8'hFF};

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	thumb_data_processing_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	tdpu_exec_checker exec_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.s_tvalid         (s_tvalid),
		.s_tready         (s_tready),
		.s_tdata          (s_tdata),
		.m_tvalid         (m_tvalid),
		.m_tready         (m_tready),
		.m_tdata          (m_tdata),
		.m_tuser          (m_tuser),
		.mismatches       (mismatches),
		.pending          (pending),
		.checked          (checked),
		.unsupported_seen (unsupported_seen)
	);

	// Receiver: ready by default, with random stall bursts while stalls are enabled.
	always @(posedge clk) begin
		if (stall_left > 1) begin
			stall_left <= stall_left - 1;
		end else if (stall_left == 1) begin
			stall_left <= 0;
			m_tready <= 1'b1;
		end else if (sink_stalls && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(1, 19);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= StallLimit) begin
			$display("Timeout: no item moved for %0d cycles", StallLimit);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic logic [15:0] enc_shift(input shift_kind_t kind, input logic [4:0] amt,
		input logic [2:0] rs, input logic [2:0] rd);
		return {FmtShift, kind, amt, rs, rd};
	endfunction

	function automatic logic [15:0] enc_addsub(input logic imm_form, input logic subtract,
		input logic [2:0] rn, input logic [2:0] rs, input logic [2:0] rd);
		return {FmtAddSub, imm_form, subtract, rn, rs, rd};
	endfunction

	function automatic logic [15:0] enc_imm(input imm_op_t op, input logic [2:0] rd,
		input logic [7:0] imm);
		return {FmtImm8, op, rd, imm};
	endfunction

	function automatic logic [15:0] enc_alu(input alu_op_t op, input logic [2:0] rs,
		input logic [2:0] rd);
		return {FmtAluReg, op, rs, rd};
	endfunction

	// Called right after the clock rises; returns once the item has been accepted.
	task automatic issue(input logic [15:0] ins);
		if (src_gaps && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= ins;
		sent++;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	initial begin
		logic [15:0] ins;
		logic [7:0]  imm;
		int          pick;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: load corner values, then hit every format and opcode.
		issue(enc_imm(IMM_MOV, 3'd0, 8'h00));
		issue(enc_imm(IMM_MOV, 3'd1, 8'hFF));
		issue(enc_imm(IMM_MOV, 3'd4, 8'd32));
		issue(enc_shift(SH_LSL, 5'd24, 3'd1, 3'd3));
		issue(enc_shift(SH_LSR, 5'd0, 3'd3, 3'd6));
		issue(enc_shift(SH_ASR, 5'd0, 3'd3, 3'd6));
		issue(enc_shift(SH_LSL, 5'd0, 3'd3, 3'd6));
		issue(enc_addsub(1'b0, 1'b0, 3'd3, 3'd3, 3'd6));
		issue(enc_addsub(1'b0, 1'b1, 3'd1, 3'd3, 3'd6));
		issue(enc_addsub(1'b1, 1'b0, 3'd7, 3'd1, 3'd6));
		issue(enc_addsub(1'b1, 1'b1, 3'd7, 3'd0, 3'd6));
		issue(enc_imm(IMM_CMP, 3'd1, 8'hFF));
		issue(enc_imm(IMM_ADD, 3'd6, 8'hFF));
		issue(enc_imm(IMM_SUB, 3'd6, 8'hFF));
		// Odd opcodes take r4 (a shift of 32), even ones r3 (low byte zero).
		for (int op = 0; op < 16; op++)
			issue(enc_alu(alu_op_t'(op), op[0] ? 3'd4 : 3'd3, 3'd6));
		issue(16'hFFFF);
		issue(16'h4400);
		wait_for_results();

		for (int n = 0; n < ItemCount; n++) begin
			if (n % 100 == 0) begin
				src_gaps = (n < QuietFrom) && ($urandom_range(0, 2) != 0);
				sink_stalls <= (n < QuietFrom) && ($urandom_range(0, 2) != 0);
			end
			if (n == 350)
				wait_for_results();
			imm = ($urandom_range(0, 3) == 0) ? imm_corners[$urandom_range(0, 5)] :
				8'($urandom());
			pick = $urandom_range(0, 99);
			if (pick < 14)
				ins = enc_shift(shift_kind_t'($urandom_range(0, 2)),
					($urandom_range(0, 3) == 0) ? 5'd0 : 5'($urandom()),
					3'($urandom()), 3'($urandom()));
			else if (pick < 28)
				ins = {FmtAddSub, 11'($urandom())};
			else if (pick < 50)
				ins = enc_imm(imm_op_t'($urandom_range(0, 3)), 3'($urandom()), imm);
			else if (pick < 92)
				ins = enc_alu(alu_op_t'($urandom_range(0, 15)), 3'($urandom()), 3'($urandom()));
			else
				ins = 16'($urandom());
			issue(ins);
		end

		wait_for_results();
		repeat (8) @(posedge clk);
		$display("Summary: %0d instructions sent, %0d results checked, %0d of them unsupported.",
			sent, checked, unsupported_seen);
		$display("Covered all four formats and every ALU opcode under sender gaps and stalls.");
		if (mismatches == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

/* filelist.f */
src/tdpu_pkg.sv
src/tdpu_ram.sv
src/tdpu_exec.sv
src/thumb_data_processing_unit.sv
tb/tdpu_exec_checker.sv
tb/tb_thumb_data_processing_unit.sv
